// ----- hdl/oot_pkg.sv -----
// Package for the one-to-one ownership table.
// Holds the command and status codes, the table entry layout and the
// control and status structs shared by the controller and the datapath.
package oot_pkg;

    localparam logic [2:0] CMD_REGISTER     = 3'd0;
    localparam logic [2:0] CMD_UNREG_CLIENT = 3'd1;
    localparam logic [2:0] CMD_UNREG_ENTITY = 3'd2;
    localparam logic [2:0] CMD_FIND_CLIENT  = 3'd3;
    localparam logic [2:0] CMD_FIND_ENTITY  = 3'd4;
    localparam logic [2:0] CMD_OWNS         = 3'd5;
    localparam logic [2:0] CMD_CLEAR        = 3'd6;

    localparam logic [3:0] ST_REGISTERED   = 4'd0;
    localparam logic [3:0] ST_ALREADY      = 4'd1;
    localparam logic [3:0] ST_CLIENT_OTHER = 4'd2;
    localparam logic [3:0] ST_ENTITY_OWNED = 4'd3;
    localparam logic [3:0] ST_BAD_CLIENT   = 4'd4;
    localparam logic [3:0] ST_BAD_ENTITY   = 4'd5;
    localparam logic [3:0] ST_REMOVED      = 4'd6;
    localparam logic [3:0] ST_NOT_FOUND    = 4'd7;
    localparam logic [3:0] ST_FOUND        = 4'd8;
    localparam logic [3:0] ST_OWNS         = 4'd9;
    localparam logic [3:0] ST_CLEARED      = 4'd10;
    localparam logic [3:0] ST_FULL         = 4'd11;

    typedef struct packed {
        logic        valid;
        logic [31:0] client;
        logic [31:0] entity;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pos_z;
    } oot_entry_t;

    typedef struct packed {
        logic load;
        logic scan_rd;
        logic sweep_wr;
        logic finish;
    } oot_ctl_t;

    typedef struct packed {
        logic addr_last;
        logic is_clear;
        logic no_scan;
    } oot_stat_t;

endpackage

// ----- hdl/oot_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing; width and depth are parameters.
module oot_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hdl/oot_ctrl.sv -----
// Controller state machine of the ownership table.
// Depends on oot_pkg for the control and status structs.
module oot_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output oot_pkg::oot_ctl_t ctl,
    input  oot_pkg::oot_stat_t stat
);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_DRAIN,
        S_CLEAR,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        ctl            = '0;
        case (state_reg)
            S_INIT:
            begin
                ctl.sweep_wr = 1'b1;
                if (stat.addr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (stat.is_clear)
                begin
                    state_next = S_CLEAR;
                end
                else if (stat.no_scan)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                ctl.scan_rd = 1'b1;
                if (stat.addr_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_FINISH;
            end
            S_CLEAR:
            begin
                ctl.sweep_wr = 1'b1;
                if (stat.addr_last)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    ctl.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- hdl/oot_dpath.sv -----
// Datapath of the ownership table: command registers, scan address counter,
// match trackers, entry count, table RAM and result registers.
// Depends on oot_pkg and oot_ram.
module oot_dpath #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  oot_pkg::oot_ctl_t  ctl,
    output oot_pkg::oot_stat_t stat,
    input  logic [2:0]         cmd,
    input  logic [31:0]        client_key,
    input  logic [31:0]        entity_key,
    input  logic [31:0]        pos_x_in,
    input  logic [31:0]        pos_y_in,
    input  logic [31:0]        pos_z_in,
    output logic [3:0]         status,
    output logic [31:0]        client_out,
    output logic [31:0]        entity_out,
    output logic [31:0]        pos_x_out,
    output logic [31:0]        pos_y_out,
    output logic [31:0]        pos_z_out,
    output logic [6:0]         entry_count
);

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam int EW = $bits(oot_pkg::oot_entry_t);
    localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_ENTRIES - 1);

    logic [2:0]  cmd_reg;
    logic [31:0] ck_reg;
    logic [31:0] ek_reg;
    logic [31:0] px_reg;
    logic [31:0] py_reg;
    logic [31:0] pz_reg;

    logic [AW-1:0] addr_reg;
    logic [AW-1:0] eval_addr_reg;
    logic          eval_pend_reg;

    logic                 cm_hit_reg;
    logic [AW-1:0]        cm_slot_reg;
    oot_pkg::oot_entry_t  cm_entry_reg;
    logic                 em_hit_reg;
    logic [AW-1:0]        em_slot_reg;
    oot_pkg::oot_entry_t  em_entry_reg;
    logic                 free_hit_reg;
    logic [AW-1:0]        free_slot_reg;

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    logic [EW-1:0]       rd_word;
    oot_pkg::oot_entry_t rd_entry;
    oot_pkg::oot_entry_t new_entry;
    oot_pkg::oot_entry_t res_entry;
    oot_pkg::oot_entry_t fin_data;
    logic [3:0]          res_status;
    logic                fin_we;
    logic [AW-1:0]       fin_addr;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [EW-1:0] ram_wdata;

    logic [3:0]  status_reg;
    logic [31:0] client_out_reg;
    logic [31:0] entity_out_reg;
    logic [31:0] pos_x_out_reg;
    logic [31:0] pos_y_out_reg;
    logic [31:0] pos_z_out_reg;
    logic [6:0]  entry_count_reg;

    assign rd_entry = rd_word;

    assign stat.addr_last = (addr_reg == LAST_ADDR);
    assign stat.is_clear  = (cmd_reg == oot_pkg::CMD_CLEAR);
    assign stat.no_scan   = (cmd_reg > oot_pkg::CMD_OWNS) && (cmd_reg != oot_pkg::CMD_CLEAR);

    always_comb
    begin
        new_entry.valid  = 1'b1;
        new_entry.client = ck_reg;
        new_entry.entity = ek_reg;
        new_entry.pos_x  = px_reg;
        new_entry.pos_y  = py_reg;
        new_entry.pos_z  = pz_reg;
    end

    always_comb
    begin
        res_status = oot_pkg::ST_NOT_FOUND;
        res_entry  = '0;
        fin_we     = 1'b0;
        fin_addr   = free_slot_reg;
        fin_data   = '0;
        count_next = count_reg;
        case (cmd_reg)
            oot_pkg::CMD_REGISTER:
            begin
                if (ck_reg == 32'd0)
                begin
                    res_status = oot_pkg::ST_BAD_CLIENT;
                end
                else if (ek_reg == 32'd0)
                begin
                    res_status = oot_pkg::ST_BAD_ENTITY;
                end
                else if (cm_hit_reg)
                begin
                    res_status = (cm_entry_reg.entity == ek_reg) ?
                                 oot_pkg::ST_ALREADY : oot_pkg::ST_CLIENT_OTHER;
                    res_entry  = cm_entry_reg;
                end
                else if (em_hit_reg)
                begin
                    res_status = oot_pkg::ST_ENTITY_OWNED;
                    res_entry  = em_entry_reg;
                end
                else if (!free_hit_reg)
                begin
                    res_status = oot_pkg::ST_FULL;
                end
                else
                begin
                    res_status = oot_pkg::ST_REGISTERED;
                    res_entry  = new_entry;
                    fin_we     = 1'b1;
                    fin_data   = new_entry;
                    count_next = count_reg + CW'(1);
                end
            end
            oot_pkg::CMD_UNREG_CLIENT:
            begin
                if (ck_reg == 32'd0)
                begin
                    res_status = oot_pkg::ST_BAD_CLIENT;
                end
                else if (cm_hit_reg)
                begin
                    res_status = oot_pkg::ST_REMOVED;
                    res_entry  = cm_entry_reg;
                    fin_we     = 1'b1;
                    fin_addr   = cm_slot_reg;
                    if (count_reg != '0)
                    begin
                        count_next = count_reg - CW'(1);
                    end
                end
            end
            oot_pkg::CMD_UNREG_ENTITY:
            begin
                if (ek_reg == 32'd0)
                begin
                    res_status = oot_pkg::ST_BAD_ENTITY;
                end
                else if (em_hit_reg)
                begin
                    res_status = oot_pkg::ST_REMOVED;
                    res_entry  = em_entry_reg;
                    fin_we     = 1'b1;
                    fin_addr   = em_slot_reg;
                    if (count_reg != '0)
                    begin
                        count_next = count_reg - CW'(1);
                    end
                end
            end
            oot_pkg::CMD_FIND_CLIENT:
            begin
                if (cm_hit_reg)
                begin
                    res_status = oot_pkg::ST_FOUND;
                    res_entry  = cm_entry_reg;
                end
            end
            oot_pkg::CMD_FIND_ENTITY:
            begin
                if (em_hit_reg)
                begin
                    res_status = oot_pkg::ST_FOUND;
                    res_entry  = em_entry_reg;
                end
            end
            oot_pkg::CMD_OWNS:
            begin
                if (cm_hit_reg && (cm_entry_reg.entity == ek_reg))
                begin
                    res_status = oot_pkg::ST_OWNS;
                    res_entry  = cm_entry_reg;
                end
            end
            oot_pkg::CMD_CLEAR:
            begin
                res_status = oot_pkg::ST_CLEARED;
                count_next = '0;
            end
            default:
            begin
                res_status = oot_pkg::ST_NOT_FOUND;
            end
        endcase
    end

    assign ram_we    = ctl.sweep_wr || (ctl.finish && fin_we);
    assign ram_waddr = ctl.sweep_wr ? addr_reg : fin_addr;
    assign ram_wdata = ctl.sweep_wr ? '0 : fin_data;

    oot_ram #(
        .WIDTH(EW),
        .DEPTH(TABLE_ENTRIES)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(addr_reg),
        .rdata(rd_word)
    );

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg <= cmd;
            ck_reg  <= client_key;
            ek_reg  <= entity_key;
            px_reg  <= pos_x_in;
            py_reg  <= pos_y_in;
            pz_reg  <= pos_z_in;
        end
        eval_addr_reg <= addr_reg;
        if (eval_pend_reg && rd_entry.valid && !cm_hit_reg && (rd_entry.client == ck_reg))
        begin
            cm_slot_reg  <= eval_addr_reg;
            cm_entry_reg <= rd_entry;
        end
        if (eval_pend_reg && rd_entry.valid && !em_hit_reg && (rd_entry.entity == ek_reg))
        begin
            em_slot_reg  <= eval_addr_reg;
            em_entry_reg <= rd_entry;
        end
        if (eval_pend_reg && !rd_entry.valid && !free_hit_reg)
        begin
            free_slot_reg <= eval_addr_reg;
        end
        if (ctl.finish)
        begin
            status_reg      <= res_status;
            client_out_reg  <= res_entry.client;
            entity_out_reg  <= res_entry.entity;
            pos_x_out_reg   <= res_entry.pos_x;
            pos_y_out_reg   <= res_entry.pos_y;
            pos_z_out_reg   <= res_entry.pos_z;
            entry_count_reg <= 7'(count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg      <= '0;
            eval_pend_reg <= 1'b0;
            cm_hit_reg    <= 1'b0;
            em_hit_reg    <= 1'b0;
            free_hit_reg  <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            eval_pend_reg <= ctl.scan_rd;
            if (ctl.load)
            begin
                addr_reg <= '0;
            end
            else if (ctl.scan_rd || ctl.sweep_wr)
            begin
                addr_reg <= addr_reg + AW'(1);
            end
            if (ctl.load)
            begin
                cm_hit_reg   <= 1'b0;
                em_hit_reg   <= 1'b0;
                free_hit_reg <= 1'b0;
            end
            else if (eval_pend_reg)
            begin
                if (rd_entry.valid && (rd_entry.client == ck_reg))
                begin
                    cm_hit_reg <= 1'b1;
                end
                if (rd_entry.valid && (rd_entry.entity == ek_reg))
                begin
                    em_hit_reg <= 1'b1;
                end
                if (!rd_entry.valid)
                begin
                    free_hit_reg <= 1'b1;
                end
            end
            if (ctl.finish)
            begin
                count_reg <= count_next;
            end
        end
    end

    assign status      = status_reg;
    assign client_out  = client_out_reg;
    assign entity_out  = entity_out_reg;
    assign pos_x_out   = pos_x_out_reg;
    assign pos_y_out   = pos_y_out_reg;
    assign pos_z_out   = pos_z_out_reg;
    assign entry_count = entry_count_reg;

endmodule

// ----- hdl/one_to_one_ownership_table.sv -----
// One-to-one ownership table: pairs a client id with an entity id and a
// stored three-word position, one entry per pair.
// Depends on oot_pkg, oot_ctrl, oot_dpath and oot_ram.
//
// Usage:
// Commands enter on the input channel (in_valid/in_ready) and each one gives
// exactly one result transfer on the output channel (out_valid/out_ready).
// Lookup commands walk the table RAM one entry per cycle through its single
// read port, so a register, unregister, find or owns command reads every
// entry before out_valid rises. Clear writes every entry through the
// single write port. The unused command code skips the scan and answers
// with ST_NOT_FOUND. One command is in work at a time; in_ready returns in
// the same cycle that out_valid rises.
// After reset the block clears the table RAM entry by entry with in_ready
// low, then accepts commands.
// The result sits in an output register. While the receiver stalls, the
// block can already take and work on the next command; that command then
// waits in its final state until the held result is transferred.
module one_to_one_ownership_table #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  cmd,
    input  logic [31:0] client_key,
    input  logic [31:0] entity_key,
    input  logic [31:0] pos_x_in,
    input  logic [31:0] pos_y_in,
    input  logic [31:0] pos_z_in,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  status,
    output logic [31:0] client_out,
    output logic [31:0] entity_out,
    output logic [31:0] pos_x_out,
    output logic [31:0] pos_y_out,
    output logic [31:0] pos_z_out,
    output logic [6:0]  entry_count
);

    oot_pkg::oot_ctl_t  ctl;
    oot_pkg::oot_stat_t stat;

    oot_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .ctl      (ctl),
        .stat     (stat)
    );

    oot_dpath #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .stat       (stat),
        .cmd        (cmd),
        .client_key (client_key),
        .entity_key (entity_key),
        .pos_x_in   (pos_x_in),
        .pos_y_in   (pos_y_in),
        .pos_z_in   (pos_z_in),
        .status     (status),
        .client_out (client_out),
        .entity_out (entity_out),
        .pos_x_out  (pos_x_out),
        .pos_y_out  (pos_y_out),
        .pos_z_out  (pos_z_out),
        .entry_count(entry_count)
    );

endmodule

// ----- hdl/oot_checker.sv -----
// Port-level checks for the ownership table, bound to its top level.
// Depends on oot_pkg for the status codes.
module oot_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [3:0]  status,
    input logic [31:0] client_out,
    input logic [31:0] entity_out,
    input logic [6:0]  entry_count
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status)
            && $stable(client_out) && $stable(entity_out) && $stable(entry_count))
        else $error("result changed while stalled");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status <= oot_pkg::ST_FULL)
        else $error("status code out of range");

    a_clear_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == oot_pkg::ST_CLEARED) |-> entry_count == 7'd0)
        else $error("clear left a nonzero count");

    a_no_entry: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == oot_pkg::ST_NOT_FOUND || status == oot_pkg::ST_FULL
            || status == oot_pkg::ST_BAD_CLIENT || status == oot_pkg::ST_BAD_ENTITY
            || status == oot_pkg::ST_CLEARED)
        |-> client_out == 32'd0 && entity_out == 32'd0)
        else $error("entry reported with a no-match status");

    a_ids_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == oot_pkg::ST_REGISTERED || status == oot_pkg::ST_FOUND
            || status == oot_pkg::ST_REMOVED || status == oot_pkg::ST_OWNS)
        |-> client_out != 32'd0 && entity_out != 32'd0)
        else $error("matched entry carries a zero id");

endmodule

bind one_to_one_ownership_table oot_checker u_oot_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .client_out (client_out),
    .entity_out (entity_out),
    .entry_count(entry_count)
);
